[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions in the LED effect checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/lsfx_pkg.sv]
// ---------------------------------------------------------------------------
// LED strip effect package
// Types, register codes, mode codes and small arithmetic helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package lsfx_pkg;

   localparam int unsigned SPEED_W    = 16;
   localparam int unsigned CHAN_W     = 8;
   localparam int unsigned IDX_W      = 4;
   localparam int unsigned MODE_W     = 3;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // Effect modes.
   localparam logic [MODE_W-1:0] MODE_OFF     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_RPM     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_RAINBOW = 3'd2;
   localparam logic [MODE_W-1:0] MODE_BREATH  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SOLID   = 3'd4;

   // Register indexes on the CSR port.
   localparam logic [CSR_IDX_W-1:0] REG_LED_MODE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SOLID_RED   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SOLID_GREEN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SOLID_BLUE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BRIGHTNESS  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RED_LINE    = 3'd5;

   localparam logic [CHAN_W-1:0]  BRIGHT_RESET   = 8'd255;
   localparam logic [SPEED_W-1:0] RED_LINE_RESET = 16'd8000;
   localparam logic [CHAN_W-1:0]  CHAN_MAX       = 8'd255;

   // Breathing ramp: period of 100 frames, peak at 50.
   localparam logic [6:0]  BREATH_LAST  = 7'd99;
   localparam logic [6:0]  BREATH_HALF  = 7'd50;
   localparam logic [6:0]  BREATH_FULL  = 7'd100;
   // 2^16 * 255 / 50 rounded up, plus 20; exact for ramp steps up to 50
   localparam logic [18:0] BREATH_RECIP = 19'd334254;

   // HSV sector boundaries, 43 hue steps per sector; the last sector has 41.
   localparam logic [7:0] HUE_SECTOR = 8'd43;

   typedef struct packed {
      logic [MODE_W-1:0]  led_mode;
      logic [CHAN_W-1:0]  solid_red;
      logic [CHAN_W-1:0]  solid_green;
      logic [CHAN_W-1:0]  solid_blue;
      logic [CHAN_W-1:0]  brightness;
      logic [SPEED_W-1:0] red_line;
   } cfg_type;

   // One classified frame, handed from the front end to the pixel engine.
   typedef struct packed {
      logic [MODE_W-1:0]  led_mode;
      logic               simulator_flag;
      logic               over_rev;
      logic               blink_phase;
      logic [SPEED_W-1:0] engine_speed;
      logic [CHAN_W-1:0]  hue_base;
      logic [CHAN_W-1:0]  breath_level;
   } frame_desc_type;

   // Floor division of a product of two 8-bit values by 255.
   function automatic logic [CHAN_W-1:0] div255(input logic [15:0] p);
      logic [16:0] s;
      s = 17'(p) + 17'(p[15:8]) + 17'd1;
      return s[15:8];
   endfunction

   // Breathing level m*255/50 on the rising half, (100-m)*255/50 on the falling half.
   function automatic logic [CHAN_W-1:0] breath_level(input logic [6:0] m);
      logic [5:0]  x;
      logic [24:0] p;
      x = (m < BREATH_HALF) ? m[5:0] : 6'(BREATH_FULL - m);
      p = 25'(x) * 25'(BREATH_RECIP);
      return p[23:16];
   endfunction

endpackage

`default_nettype wire

[rtl/core/lsfx_if.sv]
// ---------------------------------------------------------------------------
// LED strip effect channels
// Valid/ready channels for frame ticks and for pixel results.
// ---------------------------------------------------------------------------
`default_nettype none

interface lsfx_req_if;
   logic                         valid;
   logic                         ready;
   logic [lsfx_pkg::SPEED_W-1:0] engine_speed;
   logic                         simulator_flag;

   modport source (output valid, output engine_speed, output simulator_flag, input ready);
   modport sink   (input valid, input engine_speed, input simulator_flag, output ready);
endinterface

interface lsfx_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lsfx_pkg::IDX_W-1:0]  led_index;
   logic [lsfx_pkg::CHAN_W-1:0] red;
   logic [lsfx_pkg::CHAN_W-1:0] green;
   logic [lsfx_pkg::CHAN_W-1:0] blue;
   logic                        last_pixel;

   modport source (output valid, output led_index, output red, output green, output blue,
                   output last_pixel, input ready);
   modport sink   (input valid, input led_index, input red, input green, input blue,
                   input last_pixel, output ready);
endinterface

`default_nettype wire

[rtl/core/lsfx_csr.sv]
// ---------------------------------------------------------------------------
// LED strip effect registers
// Write-only configuration registers with a mode-write strobe.
// ---------------------------------------------------------------------------
`default_nettype none

module lsfx_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [lsfx_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lsfx_pkg::CSR_DATA_W-1:0] csr_wdata,
   output lsfx_pkg::cfg_type                    cfg,
   output logic                                 mode_write
);

   lsfx_pkg::cfg_type cfg_ff;
   lsfx_pkg::cfg_type cfg_in;

   // Register decode; indexes past the list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            lsfx_pkg::REG_LED_MODE:    cfg_in.led_mode    = csr_wdata[lsfx_pkg::MODE_W-1:0];
            lsfx_pkg::REG_SOLID_RED:   cfg_in.solid_red   = csr_wdata[lsfx_pkg::CHAN_W-1:0];
            lsfx_pkg::REG_SOLID_GREEN: cfg_in.solid_green = csr_wdata[lsfx_pkg::CHAN_W-1:0];
            lsfx_pkg::REG_SOLID_BLUE:  cfg_in.solid_blue  = csr_wdata[lsfx_pkg::CHAN_W-1:0];
            lsfx_pkg::REG_BRIGHTNESS:  cfg_in.brightness  = csr_wdata[lsfx_pkg::CHAN_W-1:0];
            lsfx_pkg::REG_RED_LINE:    cfg_in.red_line    = csr_wdata[lsfx_pkg::SPEED_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.led_mode    <= lsfx_pkg::MODE_OFF;
         cfg_ff.solid_red   <= '0;
         cfg_ff.solid_green <= '0;
         cfg_ff.solid_blue  <= '0;
         cfg_ff.brightness  <= lsfx_pkg::BRIGHT_RESET;
         cfg_ff.red_line    <= lsfx_pkg::RED_LINE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg        = cfg_ff;
   assign mode_write = csr_we && (csr_index == lsfx_pkg::REG_LED_MODE);

endmodule

`default_nettype wire

[rtl/core/lsfx_front.sv]
// ---------------------------------------------------------------------------
// LED strip effect front end
// Takes frame ticks, advances frame state and classifies each frame.
// ---------------------------------------------------------------------------
`default_nettype none

module lsfx_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  lsfx_pkg::cfg_type      cfg,
   input  wire logic              mode_write,
   lsfx_req_if.sink               req_bus,
   output logic                   push_valid,
   input  wire logic              push_ready,
   output lsfx_pkg::frame_desc_type push_desc
);

   logic [31:0] frame_count_ff;
   logic [31:0] frame_count_in;
   logic [6:0]  breath_step_ff;
   logic [6:0]  breath_step_in;
   logic        blink_ff;
   logic        blink_in;
   logic        accept;
   logic        over_rev;

   assign req_bus.ready = push_ready;
   assign push_valid    = req_bus.valid;
   assign accept        = req_bus.valid && push_ready;

   // Next frame state. The ramp step follows the counter modulo 100 and
   // restarts at zero when the 32-bit counter wraps.
   always_comb begin
      frame_count_in = frame_count_ff + 32'd1;
      if (&frame_count_ff) begin
         breath_step_in = '0;
      end else if (breath_step_ff == lsfx_pkg::BREATH_LAST) begin
         breath_step_in = '0;
      end else begin
         breath_step_in = breath_step_ff + 7'd1;
      end
      // Bar count reaches the strip length exactly when speed >= red line.
      over_rev = (cfg.led_mode == lsfx_pkg::MODE_RPM) &&
                 ((cfg.red_line == '0) || (req_bus.engine_speed >= cfg.red_line));
      blink_in = blink_ff ^ over_rev;
   end

   // Frame descriptor for the pixel engine.
   always_comb begin
      push_desc.led_mode       = cfg.led_mode;
      push_desc.simulator_flag = req_bus.simulator_flag;
      push_desc.over_rev       = over_rev;
      push_desc.blink_phase    = blink_in;
      push_desc.engine_speed   = req_bus.engine_speed;
      push_desc.hue_base       = {frame_count_in[6:0], 1'b0};
      push_desc.breath_level   = lsfx_pkg::breath_level(breath_step_in);
   end

   // A mode write restarts the frame count; the blink phase carries on.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= '0;
         breath_step_ff <= '0;
         blink_ff       <= 1'b0;
      end else if (mode_write) begin
         frame_count_ff <= '0;
         breath_step_ff <= '0;
      end else if (accept) begin
         frame_count_ff <= frame_count_in;
         breath_step_ff <= breath_step_in;
         blink_ff       <= blink_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/lsfx_queue.sv]
// ---------------------------------------------------------------------------
// LED strip effect frame queue
// Two-entry queue of frame descriptors between front end and pixel engine.
// ---------------------------------------------------------------------------
`default_nettype none

module lsfx_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   output logic                     push_ready,
   input  lsfx_pkg::frame_desc_type push_desc,
   output logic                     pop_valid,
   input  wire logic                pop_ready,
   output lsfx_pkg::frame_desc_type pop_desc
);

   lsfx_pkg::frame_desc_type slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       push;
   logic       pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_desc   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Occupancy tracking.
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   // Descriptor storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

`default_nettype wire

[rtl/core/lsfx_back.sv]
// ---------------------------------------------------------------------------
// LED strip effect pixel engine
// Walks the strip one LED per cycle unless stalled, driving the pixel result register.
// ---------------------------------------------------------------------------
`default_nettype none

module lsfx_back #(
   parameter int unsigned LED_COUNT = 12
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  lsfx_pkg::cfg_type        cfg,
   input  wire logic                pop_valid,
   output logic                     pop_ready,
   input  lsfx_pkg::frame_desc_type pop_desc,
   lsfx_rsp_if.source               rsp_bus
);

   localparam int unsigned PIX_W = $clog2(LED_COUNT);
   localparam int unsigned ACC_W = lsfx_pkg::SPEED_W + $clog2(LED_COUNT + 1);
   localparam logic [PIX_W-1:0] LAST_PIX   = PIX_W'(LED_COUNT - 1);
   localparam logic [PIX_W:0]   GREEN_END  = (PIX_W+1)'(LED_COUNT / 3);
   localparam logic [PIX_W:0]   YELLOW_END = (PIX_W+1)'(LED_COUNT * 2 / 3);
   localparam logic [PIX_W:0]   STRIP_LEN  = (PIX_W+1)'(LED_COUNT);
   localparam logic [7:0]       HUE_QUOT   = 8'(256 / LED_COUNT);
   localparam logic [PIX_W:0]   HUE_REM    = (PIX_W+1)'(256 % LED_COUNT);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef enum logic [2:0] {
      SEC_RED_RISE,
      SEC_GREEN_RISE,
      SEC_GREEN_HOLD,
      SEC_BLUE_RISE,
      SEC_BLUE_HOLD,
      SEC_RED_HOLD
   } sector_type;

   state_type                 state_ff;
   state_type                 state_in;
   lsfx_pkg::frame_desc_type  desc_ff;
   lsfx_pkg::frame_desc_type  desc_in;
   logic [ACC_W-1:0]          speed_n_ff;
   logic [ACC_W-1:0]          speed_n_in;
   logic [ACC_W-1:0]          acc_ff;
   logic [ACC_W-1:0]          acc_in;
   logic [PIX_W-1:0]          pix_ff;
   logic [PIX_W-1:0]          pix_in;
   logic [7:0]                hue_off_ff;
   logic [7:0]                hue_off_in;
   logic [PIX_W:0]            hue_rem_ff;
   logic [PIX_W:0]            hue_rem_in;
   logic                      out_valid_ff;
   logic                      out_valid_in;
   logic [lsfx_pkg::IDX_W-1:0]  out_index_ff;
   logic [lsfx_pkg::IDX_W-1:0]  out_index_in;
   logic [lsfx_pkg::CHAN_W-1:0] out_red_ff;
   logic [lsfx_pkg::CHAN_W-1:0] out_red_in;
   logic [lsfx_pkg::CHAN_W-1:0] out_green_ff;
   logic [lsfx_pkg::CHAN_W-1:0] out_green_in;
   logic [lsfx_pkg::CHAN_W-1:0] out_blue_ff;
   logic [lsfx_pkg::CHAN_W-1:0] out_blue_in;
   logic                      out_last_ff;
   logic                      out_last_in;

   logic                      out_free;
   logic                      emit;
   logic                      lit;
   logic [PIX_W:0]            pix_ext;
   logic [PIX_W:0]            rem_sum;
   logic [7:0]                hue;
   logic [7:0]                sec_base;
   sector_type                sector;
   logic [5:0]                sec_pos;
   logic [8:0]                sec_pos6;
   logic [7:0]                frac;
   logic [15:0]               frac_q;
   logic [15:0]               frac_t;
   logic [7:0]                k_q;
   logic [7:0]                k_t;
   logic [7:0]                mul_a0;
   logic [7:0]                mul_a1;
   logic [7:0]                mul_a2;
   logic [15:0]               prod0;
   logic [15:0]               prod1;
   logic [15:0]               prod2;
   logic [7:0]                bright;
   logic [7:0]                pix_r;
   logic [7:0]                pix_g;
   logic [7:0]                pix_b;

   assign out_free  = !out_valid_ff || rsp_bus.ready;
   assign emit      = (state_ff == ST_RUN) && out_free;
   assign pop_ready = (state_ff == ST_IDLE);
   assign bright    = cfg.brightness;
   assign pix_ext   = {1'b0, pix_ff};

   // LED i is lit on the bar when (i+1)*red_line <= speed*LED_COUNT.
   assign lit = (acc_ff <= speed_n_ff);

   // Hue of this LED and its HSV sector.
   always_comb begin
      hue = desc_ff.hue_base + hue_off_ff;
      if (hue < lsfx_pkg::HUE_SECTOR) begin
         sector   = SEC_RED_RISE;
         sec_base = 8'd0;
      end else if (hue < 8'(2 * lsfx_pkg::HUE_SECTOR)) begin
         sector   = SEC_GREEN_RISE;
         sec_base = lsfx_pkg::HUE_SECTOR;
      end else if (hue < 8'(3 * lsfx_pkg::HUE_SECTOR)) begin
         sector   = SEC_GREEN_HOLD;
         sec_base = 8'(2 * lsfx_pkg::HUE_SECTOR);
      end else if (hue < 8'(4 * lsfx_pkg::HUE_SECTOR)) begin
         sector   = SEC_BLUE_RISE;
         sec_base = 8'(3 * lsfx_pkg::HUE_SECTOR);
      end else if (hue < 8'(5 * lsfx_pkg::HUE_SECTOR)) begin
         sector   = SEC_BLUE_HOLD;
         sec_base = 8'(4 * lsfx_pkg::HUE_SECTOR);
      end else begin
         sector   = SEC_RED_HOLD;
         sec_base = 8'(5 * lsfx_pkg::HUE_SECTOR);
      end
      sec_pos  = 6'(hue - sec_base);
      sec_pos6 = 9'(sec_pos) * 9'd6;
      frac     = sec_pos6[7:0];
      frac_q   = 16'(frac) * 16'(lsfx_pkg::CHAN_MAX);
      frac_t   = 16'(lsfx_pkg::CHAN_MAX - frac) * 16'(lsfx_pkg::CHAN_MAX);
      k_q      = lsfx_pkg::CHAN_MAX - frac_q[15:8];
      k_t      = lsfx_pkg::CHAN_MAX - frac_t[15:8];
   end

   // Three shared 8x8 multipliers, all against the brightness.
   always_comb begin
      unique case (desc_ff.led_mode)
         lsfx_pkg::MODE_RAINBOW: begin
            mul_a0 = k_q;
            mul_a1 = k_t;
            mul_a2 = '0;
         end
         lsfx_pkg::MODE_BREATH: begin
            mul_a0 = desc_ff.breath_level;
            mul_a1 = '0;
            mul_a2 = '0;
         end
         default: begin
            mul_a0 = cfg.solid_red;
            mul_a1 = cfg.solid_green;
            mul_a2 = cfg.solid_blue;
         end
      endcase
      prod0 = 16'(mul_a0) * 16'(bright);
      prod1 = 16'(mul_a1) * 16'(bright);
      prod2 = 16'(mul_a2) * 16'(bright);
   end

   // Pixel color for the current LED.
   always_comb begin
      pix_r = '0;
      pix_g = '0;
      pix_b = '0;
      unique case (desc_ff.led_mode)
         lsfx_pkg::MODE_RPM: begin
            if (desc_ff.over_rev) begin
               if (desc_ff.blink_phase) begin
                  pix_r = desc_ff.simulator_flag ? bright : '0;
                  pix_g = desc_ff.simulator_flag ? '0 : bright;
               end
            end else if (lit) begin
               if (pix_ext < GREEN_END) begin
                  pix_g = bright;
               end else if (pix_ext < YELLOW_END) begin
                  pix_r = bright;
                  pix_g = bright;
               end else begin
                  pix_r = bright;
               end
            end
         end
         lsfx_pkg::MODE_RAINBOW: begin
            unique case (sector)
               SEC_RED_RISE: begin
                  pix_r = bright;
                  pix_g = prod1[15:8];
               end
               SEC_GREEN_RISE: begin
                  pix_r = prod0[15:8];
                  pix_g = bright;
               end
               SEC_GREEN_HOLD: begin
                  pix_g = bright;
                  pix_b = prod1[15:8];
               end
               SEC_BLUE_RISE: begin
                  pix_g = prod0[15:8];
                  pix_b = bright;
               end
               SEC_BLUE_HOLD: begin
                  pix_r = prod1[15:8];
                  pix_b = bright;
               end
               default: begin
                  pix_r = bright;
                  pix_b = prod0[15:8];
               end
            endcase
         end
         lsfx_pkg::MODE_BREATH: begin
            pix_r = lsfx_pkg::div255(prod0);
            pix_g = pix_r;
            pix_b = pix_r;
         end
         lsfx_pkg::MODE_SOLID: begin
            pix_r = lsfx_pkg::div255(prod0);
            pix_g = lsfx_pkg::div255(prod1);
            pix_b = lsfx_pkg::div255(prod2);
         end
         default: ;
      endcase
   end

   // Sequencer: load a frame, then one LED per free output slot.
   always_comb begin
      state_in     = state_ff;
      desc_in      = desc_ff;
      speed_n_in   = speed_n_ff;
      acc_in       = acc_ff;
      pix_in       = pix_ff;
      hue_off_in   = hue_off_ff;
      hue_rem_in   = hue_rem_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      out_index_in = out_index_ff;
      out_red_in   = out_red_ff;
      out_green_in = out_green_ff;
      out_blue_in  = out_blue_ff;
      out_last_in  = out_last_ff;
      rem_sum      = hue_rem_ff + HUE_REM;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               desc_in    = pop_desc;
               speed_n_in = ACC_W'(pop_desc.engine_speed) * ACC_W'(LED_COUNT);
               acc_in     = ACC_W'(cfg.red_line);
               pix_in     = '0;
               hue_off_in = '0;
               hue_rem_in = '0;
               state_in   = ST_RUN;
            end
         end
         ST_RUN: begin
            if (emit) begin
               out_valid_in = 1'b1;
               out_index_in = lsfx_pkg::IDX_W'(pix_ff);
               out_red_in   = pix_r;
               out_green_in = pix_g;
               out_blue_in  = pix_b;
               out_last_in  = (pix_ff == LAST_PIX);
               acc_in       = acc_ff + ACC_W'(cfg.red_line);
               pix_in       = pix_ff + PIX_W'(1);
               // Track floor(i*256/LED_COUNT) by quotient and remainder.
               if (rem_sum >= STRIP_LEN) begin
                  hue_rem_in = rem_sum - STRIP_LEN;
                  hue_off_in = hue_off_ff + HUE_QUOT + 8'd1;
               end else begin
                  hue_rem_in = rem_sum;
                  hue_off_in = hue_off_ff + HUE_QUOT;
               end
               if (pix_ff == LAST_PIX) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      desc_ff      <= desc_in;
      speed_n_ff   <= speed_n_in;
      acc_ff       <= acc_in;
      pix_ff       <= pix_in;
      hue_off_ff   <= hue_off_in;
      hue_rem_ff   <= hue_rem_in;
      out_index_ff <= out_index_in;
      out_red_ff   <= out_red_in;
      out_green_ff <= out_green_in;
      out_blue_ff  <= out_blue_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.led_index  = out_index_ff;
   assign rsp_bus.red        = out_red_ff;
   assign rsp_bus.green      = out_green_ff;
   assign rsp_bus.blue       = out_blue_ff;
   assign rsp_bus.last_pixel = out_last_ff;

endmodule

`default_nettype wire

[rtl/core/led_strip_effect_generator.sv]
// ---------------------------------------------------------------------------
// LED strip effect generator
// Turns frame ticks into one color beat per LED for five lighting effects.
// ---------------------------------------------------------------------------
//   Channel   Direction  Beat
//   req_bus   in         one frame tick: engine_speed, simulator_flag
//   rsp_bus   out        one LED: led_index, red, green, blue, last_pixel
//   csr_*     in         register write, no read-back
//
// A frame tick is taken whenever the two-entry frame queue has room.
// The pixel engine loads a frame, then emits one LED per cycle while the output
// slot is free, and takes the next frame only after the last LED of this one.
// The output register lets the next LED be computed while a beat waits.
// Synchronous reset clears all control state; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module led_strip_effect_generator #(
   parameter int unsigned LED_COUNT = 12
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   lsfx_req_if.sink                             req_bus,
   lsfx_rsp_if.source                           rsp_bus,
   input  wire logic                            csr_we,
   input  wire logic [lsfx_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lsfx_pkg::CSR_DATA_W-1:0] csr_wdata
);

   lsfx_pkg::cfg_type        cfg;
   logic                     mode_write;
   logic                     push_valid;
   logic                     push_ready;
   lsfx_pkg::frame_desc_type push_desc;
   logic                     pop_valid;
   logic                     pop_ready;
   lsfx_pkg::frame_desc_type pop_desc;

   lsfx_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cfg        (cfg),
      .mode_write (mode_write)
   );

   lsfx_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .mode_write (mode_write),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_desc  (push_desc)
   );

   lsfx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_desc  (push_desc),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_desc   (pop_desc)
   );

   lsfx_back #(
      .LED_COUNT (LED_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_desc  (pop_desc),
      .rsp_bus   (rsp_bus)
   );

endmodule

`default_nettype wire

[rtl/core/lsfx_checker.sv]
// ---------------------------------------------------------------------------
// LED strip effect checker
// Port-level checks on pixel ordering, frame accounting and the result channel.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lsfx_checker #(
   parameter int unsigned LED_COUNT = 12
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [lsfx_pkg::IDX_W-1:0]    rsp_led_index,
   input wire logic [lsfx_pkg::CHAN_W-1:0]   rsp_red,
   input wire logic [lsfx_pkg::CHAN_W-1:0]   rsp_green,
   input wire logic [lsfx_pkg::CHAN_W-1:0]   rsp_blue,
   input wire logic                          rsp_last_pixel
);

   localparam int unsigned PIX_W = $clog2(LED_COUNT);
   localparam logic [PIX_W-1:0] LAST_PIX = PIX_W'(LED_COUNT - 1);

   logic [PIX_W-1:0] exp_pix_ff;
   logic [PIX_W-1:0] exp_pix_in;
   logic [3:0]       pending_ff;
   logic [3:0]       pending_in;
   logic             req_beat;
   logic             rsp_beat;
   logic             frame_done;

   assign req_beat   = req_valid && req_ready;
   assign rsp_beat   = rsp_valid && rsp_ready;
   assign frame_done = rsp_beat && rsp_last_pixel;

   // Expected LED position and count of frames not yet fully delivered.
   always_comb begin
      exp_pix_in = exp_pix_ff;
      if (rsp_beat) begin
         exp_pix_in = (exp_pix_ff == LAST_PIX) ? '0 : exp_pix_ff + PIX_W'(1);
      end
      pending_in = pending_ff + 4'(req_beat) - 4'(frame_done);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_pix_ff <= '0;
         pending_ff <= '0;
      end else begin
         exp_pix_ff <= exp_pix_in;
         pending_ff <= pending_in;
      end
   end

   // A waiting beat keeps its contents.
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_led_index, rsp_red, rsp_green, rsp_blue, rsp_last_pixel}), "result beat changed while stalled")

   // LEDs come out in strip order, and only the final one is flagged.
   `ASSERT_CLK_RST(a_pix_order, clock, reset, rsp_valid |-> (rsp_led_index == lsfx_pkg::IDX_W'(exp_pix_ff)) && (rsp_last_pixel == (exp_pix_ff == LAST_PIX)), "LED position or last flag out of sequence")

   // No LED beat without an accepted frame tick behind it.
   `ASSERT_CLK_RST(a_no_orphan, clock, reset, rsp_valid |-> pending_ff != 4'd0, "result beat without a pending frame")

   // Reset empties the result channel.
   `ASSERT_CLK(a_reset_idle, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind led_strip_effect_generator lsfx_checker #(
   .LED_COUNT (LED_COUNT)
) u_lsfx_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_led_index  (rsp_bus.led_index),
   .rsp_red        (rsp_bus.red),
   .rsp_green      (rsp_bus.green),
   .rsp_blue       (rsp_bus.blue),
   .rsp_last_pixel (rsp_bus.last_pixel)
);

`default_nettype wire

[tb/sv/led_strip_effect_generator_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// LED strip effect generator testbench
// Sends frame ticks through the request channel and checks every LED beat on
// the response channel against a cycle-free model of the five effects. The
// register set is reprogrammed between phases while the block is idle, and
// both channels are throttled at random, including one long response stall.
// ---------------------------------------------------------------------------

module led_strip_effect_generator_tb;
   import lsfx_pkg::*;

   localparam int unsigned LED_COUNT     = 12;
   localparam int unsigned SETTLE_CYCLES = 2 * (LED_COUNT + 1);
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned HOLD_AT_BEAT  = 400;
   localparam int unsigned HOLD_CYCLES   = 600;
   localparam int unsigned RANDOM_PHASES = 9;
   localparam int unsigned BREATH_TICKS  = 55;

   // Mode codes and register indexes with no defined meaning.
   localparam logic [MODE_W-1:0]    MODE_SPARE_LO  = 3'd5;
   localparam logic [MODE_W-1:0]    MODE_SPARE_MID = 3'd6;
   localparam logic [MODE_W-1:0]    MODE_SPARE_HI  = 3'd7;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI   = 3'd7;

   typedef struct packed {
      logic [SPEED_W-1:0] engine_speed;
      logic               simulator_flag;
   } tick_type;

   typedef struct packed {
      logic [IDX_W-1:0]  led_index;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              last_pixel;
   } pixel_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   lsfx_req_if req_if ();
   lsfx_rsp_if rsp_if ();

   led_strip_effect_generator #(
      .LED_COUNT(LED_COUNT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_if),
      .rsp_bus   (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the registers and of the effect state.
   logic [MODE_W-1:0]  mode_reg;
   logic [CHAN_W-1:0]  solid_r;
   logic [CHAN_W-1:0]  solid_g;
   logic [CHAN_W-1:0]  solid_b;
   logic [CHAN_W-1:0]  bright_reg;
   logic [SPEED_W-1:0] redline_reg;
   logic [31:0]        frame_ticks;
   logic               flash_on;

   tick_type    tick_q[$];
   pixel_type   pixel_q[$];
   int unsigned src_idle_pct;
   int unsigned snk_idle_pct;
   int unsigned error_count   = 0;
   int unsigned beats_checked = 0;
   int unsigned hold_left     = 0;
   int unsigned cycle_count   = 0;

   // Color component scaled by the brightness, floor of c*k/255.
   function automatic int unsigned dim(input int unsigned c, input int unsigned k);
      return (c * k) / 255;
   endfunction

   // Advances the effect state by one frame and queues the twelve LED colors.
   function automatic void render_frame(input logic [SPEED_W-1:0] speed, input logic sim);
      int unsigned bar;
      int unsigned lit;
      int unsigned hue;
      int unsigned region;
      int unsigned rem;
      int unsigned q;
      int unsigned tv;
      int unsigned m;
      int unsigned level;
      int unsigned r;
      int unsigned g;
      int unsigned b;
      logic        over_rev;
      pixel_type   px;
      frame_ticks = frame_ticks + 1;
      bar         = LED_COUNT;
      over_rev    = 1'b0;
      // The bar length saturates; a zero red line counts as a full bar.
      if (mode_reg == MODE_RPM) begin
         if (redline_reg != 0) begin
            lit = (speed * LED_COUNT) / redline_reg;
            bar = (lit > LED_COUNT) ? LED_COUNT : lit;
         end
         if (bar >= LED_COUNT) begin
            over_rev = 1'b1;
            flash_on = !flash_on;
         end
      end
      for (int unsigned i = 0; i < LED_COUNT; i++) begin
         r = 0;
         g = 0;
         b = 0;
         case (mode_reg)
            MODE_RPM: begin
               if (over_rev) begin
                  if (flash_on) begin
                     if (sim) r = bright_reg;
                     else g = bright_reg;
                  end
               end else if (i < bar) begin
                  // Green for the first third, yellow for the second, red after.
                  if (i >= LED_COUNT / 3) r = CHAN_MAX;
                  if (i < LED_COUNT * 2 / 3) g = CHAN_MAX;
                  r = dim(r, bright_reg);
                  g = dim(g, bright_reg);
               end
            end
            MODE_RAINBOW: begin
               // Six hue sectors of 43 steps (the last of 41) at full saturation.
               hue    = (frame_ticks * 2 + i * 256 / LED_COUNT) & 32'hFF;
               region = hue / HUE_SECTOR;
               rem    = ((hue - region * HUE_SECTOR) * 6) & 32'hFF;
               q      = (bright_reg * (255 - ((255 * rem) >> 8))) >> 8;
               tv     = (bright_reg * (255 - ((255 * (255 - rem)) >> 8))) >> 8;
               case (region)
                  0: begin
                     r = bright_reg;
                     g = tv;
                  end
                  1: begin
                     r = q;
                     g = bright_reg;
                  end
                  2: begin
                     g = bright_reg;
                     b = tv;
                  end
                  3: begin
                     g = q;
                     b = bright_reg;
                  end
                  4: begin
                     r = tv;
                     b = bright_reg;
                  end
                  default: begin
                     r = bright_reg;
                     b = q;
                  end
               endcase
            end
            MODE_BREATH: begin
               // Triangle ramp over 100 frames, peaking at frame 50.
               m     = frame_ticks % BREATH_FULL;
               level = ((m < BREATH_HALF) ? m : BREATH_FULL - m) * CHAN_MAX / BREATH_HALF;
               r     = dim(level & 32'hFF, bright_reg);
               g     = r;
               b     = r;
            end
            MODE_SOLID: begin
               r = dim(solid_r, bright_reg);
               g = dim(solid_g, bright_reg);
               b = dim(solid_b, bright_reg);
            end
            default: begin
            end
         endcase
         px.led_index  = IDX_W'(i);
         px.red        = CHAN_W'(r);
         px.green      = CHAN_W'(g);
         px.blue       = CHAN_W'(b);
         px.last_pixel = (i == LED_COUNT - 1);
         pixel_q.push_back(px);
      end
   endfunction

   function automatic void queue_tick(input logic [SPEED_W-1:0] speed, input logic sim);
      tick_type t;
      t.engine_speed   = speed;
      t.simulator_flag = sim;
      tick_q.push_back(t);
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         error_count++;
         $error("%s: expected %0d, actual %0d", name, want, got);
      end
   endfunction

   // Updates the shadow registers and drives one register write.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_LED_MODE: begin
            mode_reg    = data[MODE_W-1:0];
            frame_ticks = '0;
         end
         REG_SOLID_RED:   solid_r     = data[CHAN_W-1:0];
         REG_SOLID_GREEN: solid_g     = data[CHAN_W-1:0];
         REG_SOLID_BLUE:  solid_b     = data[CHAN_W-1:0];
         REG_BRIGHTNESS:  bright_reg  = data[CHAN_W-1:0];
         REG_RED_LINE:    redline_reg = data;
         default: begin
         end
      endcase
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   task automatic finish_writes();
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Waits until every tick is taken and every LED beat has come back.
   task automatic wait_idle();
      do @(negedge clock);
      while (tick_q.size() != 0 || req_if.valid || pixel_q.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run-time limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Tick driver: holds a beat until it is taken, then maybe pauses.
   always @(posedge clock) begin : tick_driver
      tick_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            render_frame(req_if.engine_speed, req_if.simulator_flag);
         end
         if (!req_if.valid || req_if.ready) begin
            if (tick_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
               nxt                   = tick_q.pop_front();
               req_if.valid          <= 1'b1;
               req_if.engine_speed   <= nxt.engine_speed;
               req_if.simulator_flag <= nxt.simulator_flag;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // LED monitor: checks each beat and throttles ready, with one long hold-off.
   always @(posedge clock) begin : led_monitor
      pixel_type want;
      logic      take;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            beats_checked++;
            if (pixel_q.size() == 0) begin
               error_count++;
               $error("unexpected LED beat, led_index %0d", rsp_if.led_index);
            end else begin
               want = pixel_q.pop_front();
               check_field("led_index", 8'(want.led_index), 8'(rsp_if.led_index));
               check_field("red", want.red, rsp_if.red);
               check_field("green", want.green, rsp_if.green);
               check_field("blue", want.blue, rsp_if.blue);
               check_field("last_pixel", 8'(want.last_pixel), 8'(rsp_if.last_pixel));
            end
            if (beats_checked == HOLD_AT_BEAT) hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            take = 1'b0;
         end else begin
            take = ($urandom_range(99) >= snk_idle_pct);
         end
         rsp_if.ready <= take;
      end
   end

   initial begin : stimulus
      logic [MODE_W-1:0]  pick;
      logic [CHAN_W-1:0]  lvl;
      logic [SPEED_W-1:0] line;
      int unsigned        top;
      int unsigned        n_ticks;
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_index             = REG_LED_MODE;
      csr_wdata             = '0;
      req_if.valid          = 1'b0;
      req_if.engine_speed   = '0;
      req_if.simulator_flag = 1'b0;
      rsp_if.ready          = 1'b0;
      mode_reg              = MODE_OFF;
      solid_r               = '0;
      solid_g               = '0;
      solid_b               = '0;
      bright_reg            = BRIGHT_RESET;
      redline_reg           = RED_LINE_RESET;
      frame_ticks           = '0;
      flash_on              = 1'b0;
      src_idle_pct          = 24;
      snk_idle_pct          = 86;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Out of reset the strip is off and stays black.
      queue_tick(16'hFFFF, 1'b1);
      wait_idle();

      // Bar against the default red line: empty, partial, one short, then blinking.
      write_reg(REG_LED_MODE, MODE_RPM);
      finish_writes();
      queue_tick(16'd0, 1'b0);
      queue_tick(16'd2000, 1'b1);
      queue_tick(16'd4000, 1'b0);
      queue_tick(16'd7999, 1'b1);
      queue_tick(16'd8000, 1'b1);
      queue_tick(16'd8000, 1'b0);
      queue_tick(16'hFFFF, 1'b0);
      wait_idle();

      // A zero red line forces the blink; upper data bits must be dropped.
      write_reg(REG_RED_LINE, 16'd0);
      write_reg(REG_BRIGHTNESS, 16'hFF80);
      finish_writes();
      queue_tick(16'd0, 1'b1);
      queue_tick(16'd0, 1'b0);
      wait_idle();

      // Bar count far beyond eight bits, and the widest red line.
      write_reg(REG_RED_LINE, 16'd1);
      finish_writes();
      queue_tick(16'hFFFF, 1'b1);
      wait_idle();
      write_reg(REG_RED_LINE, 16'hFFFF);
      finish_writes();
      queue_tick(16'hFFFF, 1'b0);
      queue_tick(16'hFFFE, 1'b1);
      wait_idle();

      // Rainbow at zero and at full brightness.
      write_reg(REG_LED_MODE, MODE_RAINBOW);
      write_reg(REG_BRIGHTNESS, 16'd0);
      finish_writes();
      queue_tick(16'd100, 1'b0);
      wait_idle();
      write_reg(REG_BRIGHTNESS, 16'd255);
      finish_writes();
      queue_tick(16'd200, 1'b1);
      queue_tick(16'd300, 1'b0);
      wait_idle();

      // Breathing ramp start.
      write_reg(REG_LED_MODE, MODE_BREATH);
      write_reg(REG_BRIGHTNESS, 16'd200);
      finish_writes();
      queue_tick(16'd0, 1'b0);
      queue_tick(16'd0, 1'b1);
      wait_idle();

      // Solid color at full and at minimal brightness.
      write_reg(REG_SOLID_RED, 16'd255);
      write_reg(REG_SOLID_GREEN, 16'd0);
      write_reg(REG_SOLID_BLUE, 16'h5A81);
      write_reg(REG_BRIGHTNESS, 16'd255);
      write_reg(REG_LED_MODE, MODE_SOLID);
      finish_writes();
      queue_tick(16'd1, 1'b0);
      wait_idle();
      write_reg(REG_BRIGHTNESS, 16'd1);
      finish_writes();
      queue_tick(16'd2, 1'b1);
      wait_idle();

      // Writes to undefined indexes must leave the solid color untouched.
      write_reg(REG_SPARE_LO, 16'hFFFF);
      write_reg(REG_SPARE_HI, 16'hFFFF);
      write_reg(REG_BRIGHTNESS, 16'd255);
      finish_writes();
      queue_tick(16'd3, 1'b0);
      wait_idle();

      // Undefined mode codes give black.
      write_reg(REG_LED_MODE, MODE_SPARE_LO);
      finish_writes();
      queue_tick(16'hAAAA, 1'b1);
      wait_idle();
      write_reg(REG_LED_MODE, MODE_SPARE_HI);
      finish_writes();
      queue_tick(16'h5555, 1'b0);
      wait_idle();

      // Random phases: new registers, then a burst of ticks.
      for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
         if (p == RANDOM_PHASES / 3) begin
            src_idle_pct = 86;
            snk_idle_pct = 24;
         end
         if (p == 2 * RANDOM_PHASES / 3) begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
         end
         write_reg(REG_SOLID_RED, 16'($urandom));
         write_reg(REG_SOLID_GREEN, 16'($urandom));
         write_reg(REG_SOLID_BLUE, 16'($urandom));
         case ($urandom_range(0, 3))
            0: lvl = 8'd0;
            1: lvl = 8'd255;
            default: lvl = 8'($urandom);
         endcase
         write_reg(REG_BRIGHTNESS, {8'($urandom), lvl});
         case ($urandom_range(0, 5))
            0: line = 16'd0;
            1: line = 16'd1;
            2: line = 16'hFFFF;
            default: line = 16'($urandom_range(1, 65535));
         endcase
         write_reg(REG_RED_LINE, line);
         case ($urandom_range(0, 11))
            0, 1, 2: pick = MODE_RPM;
            3, 4: pick = MODE_RAINBOW;
            5, 6: pick = MODE_BREATH;
            7, 8: pick = MODE_SOLID;
            9: pick = MODE_OFF;
            10: pick = MODE_SPARE_MID;
            default: pick = MODE_SPARE_HI;
         endcase
         // The last phase runs breathing long enough to pass the peak.
         if (p == RANDOM_PHASES - 1) pick = MODE_BREATH;
         // Sometimes keep the mode so the frame count carries on.
         if (p == 0 || p == RANDOM_PHASES - 1 || $urandom_range(0, 3) != 0) begin
            write_reg(REG_LED_MODE, {13'($urandom), pick});
         end
         finish_writes();
         n_ticks = (p == RANDOM_PHASES - 1) ? BREATH_TICKS : $urandom_range(5, 9);
         top = redline_reg + redline_reg / 4;
         if (top > 65535) top = 65535;
         for (int unsigned k = 0; k < n_ticks; k++) begin
            if (mode_reg == MODE_RPM && $urandom_range(0, 3) != 0) begin
               queue_tick(16'($urandom_range(0, top)), 1'($urandom_range(0, 1)));
            end else begin
               queue_tick(16'($urandom), 1'($urandom_range(0, 1)));
            end
         end
         wait_idle();
      end

      if (error_count == 0 && pixel_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
